// ----- sv/lmod_pkg.sv -----
// shared types, sizes and register codes of the lidar median obstacle detector
package lmod_pkg;

	// sizes
	localparam int MAX_BEAMS    = 1024;
	localparam int WINDOW_DEPTH = 5;
	localparam int RANGE_BITS   = 16;
	localparam int ADDR_W       = $clog2(MAX_BEAMS);
	localparam int BEAM_W       = $clog2(MAX_BEAMS + 1);
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int KEY_W        = RANGE_BITS + 1;
	localparam int CNT_W        = 11;
	localparam int FRAC_W       = 17;
	localparam int PROD_W       = FRAC_W + CNT_W;

	// configuration register indexes
	localparam logic [2:0] REG_HALF_CONE = 3'd0;
	localparam logic [2:0] REG_DETECT    = 3'd1;
	localparam logic [2:0] REG_VALID_MIN = 3'd2;
	localparam logic [2:0] REG_VALID_MAX = 3'd3;
	localparam logic [2:0] REG_FRACTION  = 3'd4;

	// input word
	typedef struct packed {
		logic [15:0] range_mm;
		logic        last_beam;
	} in_word_t;

	// result word
	typedef struct packed {
		logic             obstacle_detected;
		logic [CNT_W-1:0] hit_count;
		logic [CNT_W-1:0] beams_in_fov;
	} out_word_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [CNT_W-1:0]      half_cone_beams;
		logic [RANGE_BITS-1:0] detect_distance_mm;
		logic [RANGE_BITS-1:0] valid_min_mm;
		logic [RANGE_BITS-1:0] valid_max_mm;
		logic [FRAC_W-1:0]     hit_fraction_q16;
	} cfg_t;

	// per-beam control travelling down the pipeline
	typedef struct packed {
		logic              vld;
		logic              last;
		logic              cone;
		logic [BEAM_W-1:0] cnt;
	} beat_ctl_t;

endpackage

// ----- sv/lmod_window.sv -----
// sample window store: one bank per scan slot, registered read of all banks
module lmod_window (
	input  logic                                                  clk,
	input  logic                                                  we,
	input  logic [lmod_pkg::ADDR_W-1:0]                           waddr,
	input  logic [lmod_pkg::SLOT_W-1:0]                           wslot,
	input  logic [lmod_pkg::RANGE_BITS-1:0]                       wdata,
	input  logic                                                  re,
	input  logic [lmod_pkg::ADDR_W-1:0]                           raddr,
	output logic [lmod_pkg::WINDOW_DEPTH-1:0][lmod_pkg::RANGE_BITS-1:0] rdata
);
	import lmod_pkg::*;

	logic [RANGE_BITS-1:0] bank_mem [WINDOW_DEPTH][MAX_BEAMS];
	logic [WINDOW_DEPTH-1:0][RANGE_BITS-1:0] rdata_q;

	// write the current slot's bank, read every bank of the same beam
	always_ff @(posedge clk) begin
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			if (we && wslot == SLOT_W'(k)) begin
				bank_mem[k][waddr] <= wdata;
			end
			if (re) begin
				rdata_q[k] <= bank_mem[k][raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/lmod_median.sv -----
// per-beam median: qualify samples, rank them, pick the upper median, test it
module lmod_median (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  adv,
	input  lmod_pkg::cfg_t                                        cfg,
	input  lmod_pkg::beat_ctl_t                                   ctl_s1,
	input  logic [lmod_pkg::RANGE_BITS-1:0]                       range_s1,
	input  logic [lmod_pkg::SLOT_W-1:0]                           slot_s1,
	input  logic [lmod_pkg::SLOT_W-1:0]                           used_s1,
	input  logic [lmod_pkg::WINDOW_DEPTH-1:0][lmod_pkg::RANGE_BITS-1:0] rd_data,
	output lmod_pkg::beat_ctl_t                                   ctl_s3,
	output logic                                                  hit_s3
);
	import lmod_pkg::*;

	logic [WINDOW_DEPTH-1:0][KEY_W-1:0]  key_d;
	logic [SLOT_W-1:0]                   nval_d;
	logic [WINDOW_DEPTH-1:0][KEY_W-1:0]  key_s2;
	logic [SLOT_W-1:0]                   nval_s2;
	beat_ctl_t                           ctl_s2;
	logic [WINDOW_DEPTH-1:0][SLOT_W-1:0] rank_d;
	logic [WINDOW_DEPTH-1:0][KEY_W-1:0]  key_s3;
	logic [WINDOW_DEPTH-1:0][SLOT_W-1:0] rank_s3;
	logic [SLOT_W-1:0]                   nval_s3;
	beat_ctl_t                           ctl_s3_q;
	logic [RANGE_BITS-1:0]               med;

	// lane keys: invalid samples get the top bit set so they sort last
	always_comb begin
		logic [RANGE_BITS-1:0] v;
		logic                  ok;
		nval_d = '0;
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			v  = (slot_s1 == SLOT_W'(k)) ? range_s1 : rd_data[k];
			ok = (SLOT_W'(k) < used_s1) && (v != '0) && (v > cfg.valid_min_mm) &&
			     (v < cfg.valid_max_mm);
			key_d[k] = {~ok, v};
			nval_d   = nval_d + SLOT_W'(ok);
		end
	end

	// stable rank of each lane among all lanes
	always_comb begin
		logic lt;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			rank_d[i] = '0;
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				lt = (key_s2[j] < key_s2[i]) || ((key_s2[j] == key_s2[i]) && (j < i));
				if (j != i) begin
					rank_d[i] = rank_d[i] + SLOT_W'(lt);
				end
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2   <= '0;
			ctl_s3_q <= '0;
		end else if (adv) begin
			ctl_s2   <= ctl_s1;
			ctl_s3_q <= ctl_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			key_s2  <= key_d;
			nval_s2 <= nval_d;
			key_s3  <= key_s2;
			rank_s3 <= rank_d;
			nval_s3 <= nval_s2;
		end
	end

	// upper median: the valid lane whose rank is half the valid count
	always_comb begin
		med = '0;
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			if (!key_s3[k][KEY_W-1] && rank_s3[k] == (nval_s3 >> 1)) begin
				med = key_s3[k][RANGE_BITS-1:0];
			end
		end
	end

	assign hit_s3 = ctl_s3_q.cone && (nval_s3 != '0) && (med < cfg.detect_distance_mm);
	assign ctl_s3 = ctl_s3_q;

endmodule

// ----- sv/lmod_decide.sv -----
// hit counting per scan, field of view, fraction test and result register
module lmod_decide (
	input  logic                clk,
	input  logic                arst_n,
	input  lmod_pkg::cfg_t      cfg,
	input  lmod_pkg::beat_ctl_t ctl_s3,
	input  logic                hit_s3,
	input  logic                out_stall,
	output logic                hold,
	output logic                out_valid,
	output lmod_pkg::out_word_t out_word
);
	import lmod_pkg::*;

	logic [BEAM_W-1:0] hits_q;
	logic [BEAM_W-1:0] hits_total;
	logic [BEAM_W:0]   cone_beams;
	logic [BEAM_W-1:0] fov_d;
	logic              v_s4;
	logic [BEAM_W-1:0] hits_s4;
	logic [BEAM_W-1:0] fov_s4;
	logic [PROD_W-1:0] need;
	logic [PROD_W-1:0] have;
	logic              out_valid_q;
	out_word_t         out_word_q;
	logic              adv;

	// a finished scan waits while the result register is full and stalled
	assign hold = v_s4 && out_valid_q && out_stall;
	assign adv  = !hold;

	// hits including this beam, and the field of view at the last beam
	assign hits_total = hits_q + BEAM_W'(hit_s3);
	assign cone_beams = (BEAM_W + 1)'(cfg.half_cone_beams) + (BEAM_W + 1)'(1);
	assign fov_d      = (cone_beams < {1'b0, ctl_s3.cnt}) ? cone_beams[BEAM_W-1:0] :
	                    ctl_s3.cnt;

	// scan hit accumulator and last-beam stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			v_s4   <= 1'b0;
		end else if (adv) begin
			v_s4 <= ctl_s3.vld && ctl_s3.last;
			if (ctl_s3.vld) begin
				hits_q <= ctl_s3.last ? '0 : hits_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hits_s4 <= hits_total;
			fov_s4  <= fov_d;
		end
	end

	// exact fraction test: hits * 65536 >= fraction * fov
	assign need = PROD_W'(cfg.hit_fraction_q16) * PROD_W'(fov_s4);
	assign have = PROD_W'({hits_s4, 16'b0});

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && (!out_valid_q || !out_stall)) begin
			out_word_q.obstacle_detected <= (have >= need);
			out_word_q.hit_count         <= CNT_W'(hits_s4);
			out_word_q.beams_in_fov      <= CNT_W'(fov_s4);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ----- sv/lidar_median_obstacle_detector_top.sv -----
// top level of the lidar median obstacle detector: register port, scan counters, pipeline
//
//  channel | signals                              | word
//  --------+--------------------------------------+--------------------------------
//  input   | in_valid, in_stall, in_word          | range_mm, last_beam
//  output  | out_valid, out_stall, out_word       | obstacle_detected, hit_count,
//          |                                      | beams_in_fov
//  config  | psel, penable, pwrite, paddr, pwdata | five registers at 4*i
//
// One beam word is taken every cycle while the input is not stalled; the window store
// has one bank per scan slot, so a beam's new sample is written while the other slots
// are read in the same cycle. A scan's result passes stages s1 to s4, then the result register.
// After reset the registers hold their defaults and the window holds no valid scan.
// The input stalls only while a scan result waits in a full, stalled result register.
module lidar_median_obstacle_detector_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lmod_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output lmod_pkg::out_word_t out_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import lmod_pkg::*;

	cfg_t                                   cfg_q;
	logic [2:0]                             reg_idx;
	logic [BEAM_W-1:0]                      beam_q;
	logic [SLOT_W-1:0]                      slot_q;
	logic [SLOT_W-1:0]                      filled_q;
	logic                                   take;
	logic                                   store;
	logic                                   hold;
	logic                                   adv;
	beat_ctl_t                              ctl_s1;
	logic [RANGE_BITS-1:0]                  range_s1;
	logic [SLOT_W-1:0]                      slot_s1;
	logic [SLOT_W-1:0]                      used_s1;
	logic [WINDOW_DEPTH-1:0][RANGE_BITS-1:0] rd_data;
	beat_ctl_t                              ctl_s3;
	logic                                   hit_s3;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_cone_beams    <= CNT_W'(256);
			cfg_q.detect_distance_mm <= RANGE_BITS'(2000);
			cfg_q.valid_min_mm       <= RANGE_BITS'(100);
			cfg_q.valid_max_mm       <= RANGE_BITS'(65535);
			cfg_q.hit_fraction_q16   <= FRAC_W'(32768);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_HALF_CONE: cfg_q.half_cone_beams    <= pwdata[CNT_W-1:0];
				REG_DETECT:    cfg_q.detect_distance_mm <= pwdata[RANGE_BITS-1:0];
				REG_VALID_MIN: cfg_q.valid_min_mm       <= pwdata[RANGE_BITS-1:0];
				REG_VALID_MAX: cfg_q.valid_max_mm       <= pwdata[RANGE_BITS-1:0];
				REG_FRACTION:  cfg_q.hit_fraction_q16   <= pwdata[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HALF_CONE: prdata = 32'(cfg_q.half_cone_beams);
			REG_DETECT:    prdata = 32'(cfg_q.detect_distance_mm);
			REG_VALID_MIN: prdata = 32'(cfg_q.valid_min_mm);
			REG_VALID_MAX: prdata = 32'(cfg_q.valid_max_mm);
			REG_FRACTION:  prdata = 32'(cfg_q.hit_fraction_q16);
			default:       prdata = '0;
		endcase
	end

	// input handshake
	assign adv      = !hold;
	assign in_stall = hold;
	assign take     = in_valid && !in_stall;
	assign store    = take && (beam_q < BEAM_W'(MAX_BEAMS));

	// scan position: beam index, window slot, scans held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q   <= '0;
			slot_q   <= '0;
			filled_q <= '0;
		end else if (take) begin
			if (in_word.last_beam) begin
				beam_q   <= '0;
				slot_q   <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
				filled_q <= (filled_q == SLOT_W'(WINDOW_DEPTH)) ? filled_q :
				            filled_q + SLOT_W'(1);
			end else if (store) begin
				beam_q <= beam_q + BEAM_W'(1);
			end
		end
	end

	// first stage: beam control alongside the window read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= take;
			ctl_s1.last <= in_word.last_beam;
			ctl_s1.cone <= store && ({1'b0, beam_q} <= (BEAM_W + 1)'(cfg_q.half_cone_beams));
			ctl_s1.cnt  <= store ? beam_q + BEAM_W'(1) : beam_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			range_s1 <= in_word.range_mm;
			slot_s1  <= slot_q;
			used_s1  <= (filled_q == SLOT_W'(WINDOW_DEPTH)) ? filled_q : filled_q + SLOT_W'(1);
		end
	end

	lmod_window u_window (
		.clk   (clk),
		.we    (store),
		.waddr (beam_q[ADDR_W-1:0]),
		.wslot (slot_q),
		.wdata (in_word.range_mm),
		.re    (adv),
		.raddr (beam_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	lmod_median u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_q),
		.ctl_s1   (ctl_s1),
		.range_s1 (range_s1),
		.slot_s1  (slot_s1),
		.used_s1  (used_s1),
		.rd_data  (rd_data),
		.ctl_s3   (ctl_s3),
		.hit_s3   (hit_s3)
	);

	lmod_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctl_s3    (ctl_s3),
		.hit_s3    (hit_s3),
		.out_stall (out_stall),
		.hold      (hold),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

endmodule

// ----- verif/lidar_median_obstacle_detector_top_test.sv -----
`timescale 1ns / 100ps
// testbench of the lidar median obstacle detector: scan verdict scoreboard, drivers and stimulus
module lidar_median_obstacle_detector_top_test;
	import lmod_pkg::*;

	localparam int LONG_SCAN    = MAX_BEAMS + 6;
	localparam int FILL_SCAN    = 24;
	localparam int RANDOM_BEAMS = 650;
	localparam int SETTLE       = 12;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DUE_DEPTH    = 16;

	// expected scan verdicts, from a private copy of the window, counters and registers
	class scan_verdicts;
		logic [RANGE_BITS-1:0] samples [MAX_BEAMS][WINDOW_DEPTH];
		int                    filled_len [WINDOW_DEPTH];
		int                    slot, scans, beam, hits, errors;
		logic [CNT_W-1:0]      half_cone;
		logic [RANGE_BITS-1:0] detect_mm, min_mm, max_mm;
		logic [FRAC_W-1:0]     fraction;
		out_word_t             due [DUE_DEPTH];
		int                    due_rd, due_cnt;

		function new();
			half_cone = 11'd256;
			detect_mm = 16'd2000;
			min_mm    = 16'd100;
			max_mm    = 16'hFFFF;
			fraction  = 17'd32768;
			slot      = 0;
			scans     = 0;
			beam      = 0;
			hits      = 0;
			errors    = 0;
			due_rd    = 0;
			due_cnt   = 0;
			foreach (filled_len[s]) filled_len[s] = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
			REG_HALF_CONE: half_cone = val[CNT_W-1:0];
			REG_DETECT:    detect_mm = val[RANGE_BITS-1:0];
			REG_VALID_MIN: min_mm    = val[RANGE_BITS-1:0];
			REG_VALID_MAX: max_mm    = val[RANGE_BITS-1:0];
			REG_FRACTION:  fraction  = val[FRAC_W-1:0];
			default: ;
			endcase
		endfunction

		function int slots_used();
			return (scans < WINDOW_DEPTH) ? scans + 1 : WINDOW_DEPTH;
		endfunction

		// longest scan that reads only window entries written at some point
		function int longest_safe_scan();
			int lim;
			lim = MAX_BEAMS + 8;
			for (int s = 0; s < slots_used(); s++) begin
				if (s != slot && filled_len[s] < MAX_BEAMS && filled_len[s] < lim)
					lim = filled_len[s];
			end
			return lim;
		endfunction

		// upper median of the valid samples of one beam, 0 when none is valid
		function bit beam_median(int b, output logic [RANGE_BITS-1:0] med);
			logic [RANGE_BITS-1:0] vals [WINDOW_DEPTH];
			logic [RANGE_BITS-1:0] key;
			int n, j;
			n = 0;
			med = '0;
			for (int s = 0; s < slots_used(); s++) begin
				if (samples[b][s] != 0 && samples[b][s] > min_mm && samples[b][s] < max_mm) begin
					vals[n] = samples[b][s];
					n++;
				end
			end
			if (n == 0)
				return 1'b0;
			for (int a = 1; a < n; a++) begin
				key = vals[a];
				j = a;
				while (j > 0 && vals[j-1] > key) begin
					vals[j] = vals[j-1];
					j--;
				end
				vals[j] = key;
			end
			med = vals[n / 2];
			return 1'b1;
		endfunction

		// note one accepted beam word; the last beam of a scan queues a verdict
		function void take_beam(in_word_t w);
			logic [RANGE_BITS-1:0] med;
			int fov;
			out_word_t v;
			if (beam < MAX_BEAMS) begin
				samples[beam][slot] = w.range_mm;
				if (beam >= filled_len[slot])
					filled_len[slot] = beam + 1;
				if (beam <= int'(half_cone) && beam_median(beam, med) && med < detect_mm)
					hits++;
				beam++;
			end
			if (!w.last_beam)
				return;
			fov = (int'(half_cone) + 1 < beam) ? int'(half_cone) + 1 : beam;
			v.obstacle_detected = (longint'(hits) << 16) >= longint'(fraction) * longint'(fov);
			v.hit_count         = hits[CNT_W-1:0];
			v.beams_in_fov      = fov[CNT_W-1:0];
			due[(due_rd + due_cnt) % DUE_DEPTH] = v;
			due_cnt++;
			slot = (slot + 1) % WINDOW_DEPTH;
			if (scans < WINDOW_DEPTH)
				scans++;
			beam = 0;
			hits = 0;
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_verdict(out_word_t got);
			out_word_t want;
			if (due_cnt == 0) begin
				errors++;
				$display("%0t: verdict %p arrived, expected none", $time, got);
				return;
			end
			want = due[due_rd];
			due_rd = (due_rd + 1) % DUE_DEPTH;
			due_cnt--;
			check_field("obstacle_detected", want.obstacle_detected, got.obstacle_detected);
			check_field("hit_count", want.hit_count, got.hit_count);
			check_field("beams_in_fov", want.beams_in_fov, got.beams_in_fov);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid, in_stall;
	in_word_t    in_word;
	logic        out_valid, out_stall;
	out_word_t   out_word;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	int          in_calm, out_calm, scan_left;
	int unsigned cycles = 0;
	scan_verdicts verdicts = new();

	// directed scans of four beams around the validity and distance bounds
	logic [15:0] probe [20] = '{
		16'd0, 16'd100, 16'd101, 16'd999,
		16'd4999, 16'd5000, 16'd65535, 16'd1000,
		16'd65534, 16'd999, 16'd1000, 16'd2,
		16'd500, 16'd500, 16'd500, 16'd500,
		16'd0, 16'd0, 16'd0, 16'd65535
	};

	lidar_median_obstacle_detector_top dut (.*);

	always #1 clk = ~clk;

	// wait drawn per word, with occasional runs of back-to-back words
	function automatic int idle_cycles(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	// ranges clustered on the current bounds, plus empty returns and full scale
	function automatic logic [15:0] pick_range();
		case ($urandom_range(0, 9))
		0:       return 16'd0;
		1:       return 16'hFFFF;
		2:       return 16'(verdicts.min_mm + $urandom_range(0, 2) - 1);
		3:       return 16'(verdicts.max_mm + $urandom_range(0, 2) - 1);
		4, 5:    return 16'(verdicts.detect_mm + $urandom_range(0, 40) - 20);
		6, 7:    return 16'($urandom_range(verdicts.min_mm, verdicts.detect_mm));
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic int choose_scan_len();
		int len, lim;
		case ($urandom_range(0, 19))
		0:             len = 1;
		1, 2, 3, 4, 5: len = $urandom_range(1, FILL_SCAN);
		default:       len = $urandom_range(1, 8);
		endcase
		lim = verdicts.longest_safe_scan();
		return (len < lim) ? len : lim;
	endfunction

	function automatic logic [31:0] reg_value(logic [2:0] idx);
		int pick;
		pick = $urandom_range(0, 7);
		case (idx)
		REG_HALF_CONE: begin
			case (pick)
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return MAX_BEAMS;
			3:       return MAX_BEAMS - 1;
			4:       return $urandom_range(0, MAX_BEAMS);
			default: return $urandom_range(0, FILL_SCAN);
			endcase
		end
		REG_DETECT: begin
			case (pick)
			0:       return 32'd0;
			1:       return 32'd65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(200, 4000);
			endcase
		end
		REG_VALID_MIN: begin
			case (pick)
			0:       return 32'd0;
			1:       return 32'd65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(0, 300);
			endcase
		end
		REG_VALID_MAX: begin
			case (pick)
			0:       return 32'd0;
			1:       return 32'd65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(3000, 65535);
			endcase
		end
		default: begin
			case (pick)
			0:       return 32'd0;
			1:       return 32'd65536;
			2:       return 32'd131071;
			default: return $urandom_range(0, 65536);
			endcase
		end
		endcase
	endfunction

	// register write: setup, access until ready, then idle
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		verdicts.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic shuffle_registers();
		for (int r = REG_HALF_CONE; r <= REG_FRACTION; r++) begin
			if ($urandom_range(0, 1))
				write_reg(3'(r), reg_value(3'(r)));
		end
	endtask

	// valid is left high after a word so that the next one may follow at once
	task automatic send_beam(in_word_t w);
		int gap;
		gap = idle_cycles(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		verdicts.take_beam(w);
	endtask

	task automatic send_next_beam();
		in_word_t w;
		if (scan_left == 0)
			scan_left = choose_scan_len();
		w.range_mm  = pick_range();
		w.last_beam = (scan_left == 1);
		scan_left--;
		send_beam(w);
	endtask

	// block idle: every verdict in and the pipeline given time to empty
	task automatic settle();
		in_valid <= 1'b0;
		while (verdicts.due_cnt != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side stall
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = idle_cycles(out_calm);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			verdicts.check_verdict(out_word);
	end

	// run time guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("lidar_median_obstacle_detector_top_test: done, errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		in_word_t w;
		int sent, burst;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// over-long first scan, full cone, else reset defaults: fills one slot, saturates the beam count
		write_reg(REG_HALF_CONE, MAX_BEAMS);
		scan_left = LONG_SCAN;
		repeat (LONG_SCAN) send_next_beam();
		// window filling up; leaves room for later scans of up to this length
		repeat (WINDOW_DEPTH - 1) begin
			scan_left = FILL_SCAN;
			repeat (FILL_SCAN) send_next_beam();
		end
		settle();

		write_reg(REG_HALF_CONE, 32'd3);
		write_reg(REG_DETECT, 32'd1000);
		write_reg(REG_VALID_MIN, 32'd100);
		write_reg(REG_VALID_MAX, 32'd5000);
		write_reg(REG_FRACTION, 32'd65536);
		foreach (probe[i]) begin
			w.range_mm  = probe[i];
			w.last_beam = (i % 4 == 3);
			send_beam(w);
		end
		// scan of a single beam
		w.range_mm  = 16'd1;
		w.last_beam = 1'b1;
		send_beam(w);

		// random phases, some ending mid-scan so registers change inside a scan
		sent = 0;
		while (sent < RANDOM_BEAMS) begin
			settle();
			shuffle_registers();
			burst = $urandom_range(20, 150);
			repeat (burst) begin
				send_next_beam();
				sent++;
			end
		end
		while (scan_left != 0)
			send_next_beam();
		settle();

		if (verdicts.errors == 0)
			$display("lidar_median_obstacle_detector_top_test: done, clean");
		else
			$display("lidar_median_obstacle_detector_top_test: done, errors");
		$finish;
	end

endmodule
